// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl files, included by the decoder unit
// each helper expects signals named clk and arst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bfbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbd_pkg
// field kind codes and sizes for the binary field byte decoder
// ----------------------------------------------------------------------------
package bfbd_pkg;

	localparam int unsigned KindW  = 3;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned ValueW = 64;
	localparam int unsigned PosW   = 4;

	typedef logic [KindW-1:0]  kind_t;
	typedef logic [ByteW-1:0]  byte_t;
	typedef logic [ValueW-1:0] value_t;
	typedef logic [PosW-1:0]   pos_t;

	// field kind codes
	localparam kind_t KIND_U8   = 3'd0;
	localparam kind_t KIND_U16  = 3'd1;
	localparam kind_t KIND_U32  = 3'd2;
	localparam kind_t KIND_U64  = 3'd3;
	localparam kind_t KIND_ULEB = 3'd4;
	localparam kind_t KIND_SLEB = 3'd5;

	// leb128 byte positions
	localparam pos_t LEB_TOP_POS  = 4'd9;   // byte holding payload bit 63
	localparam pos_t LEB_LAST_POS = 4'd10;  // counter stops here

endpackage

// ===== hw/rtl/binary_field_byte_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_field_byte_decoder_unit
// decodes a tagged byte stream into fixed-width and leb128 integer fields
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    kind, data_byte
//  out       out_valid / out_stall  value, overflow
//  cfg       cfg_we                 cfg_wdata (little_endian)
//
//  one word per cycle sustained unless a stalled result holds the input; a
//  word is merged into the field accumulator while it sits in the input
//  register, and a finished field is loaded into the output register as that word moves on
//  the field state loop (accumulator, position, kind) closes through the field state registers alone
//  reset clears the field state and sets little_endian to 1
//  out_stall holds the output register; while a result waits there and is
//  stalled, the input register holds its word too, whether or not that word
//  finishes a field
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_field_byte_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	// input words
	input  logic                in_valid,
	output logic                in_stall,
	input  bfbd_pkg::kind_t     kind,
	input  bfbd_pkg::byte_t     data_byte,
	// result words
	output logic                out_valid,
	input  logic                out_stall,
	output bfbd_pkg::value_t    value,
	output logic                overflow
);
	import bfbd_pkg::*;

	// configuration register
	logic little_endian_q;

	// input register
	logic  valid_s1;
	kind_t kind_s1;
	byte_t byte_s1;

	// field state
	value_t acc_q;
	pos_t   pos_q;
	kind_t  kind_q;
	logic   lost_q;

	// output register
	logic   valid_s2;
	value_t value_s2;
	logic   ovf_s2;

	// step logic
	logic       advance;
	logic       step;
	kind_t      eff_kind;
	pos_t       pos_inc;
	pos_t       nbytes;
	logic [6:0] offset;      // 7 * pos
	logic [6:0] end_bit;     // 7 * (pos + 1)
	logic [6:0] payload;
	value_t     acc_d;
	pos_t       pos_d;
	kind_t      kind_d;
	logic       lost_d;
	logic       res_valid;
	value_t     res_value;
	logic       res_ovf;
	logic       field_clear;

	// the input register moves on when the output register is free or taken
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			little_endian_q <= 1'b1;
		end else if (cfg_we) begin
			little_endian_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
		end
	end

	// kind is taken from the first byte of a field only
	assign eff_kind = (pos_q == '0) ? kind_s1 : kind_q;
	assign pos_inc  = pos_q + 4'd1;
	assign nbytes   = 4'd1 << eff_kind[1:0];
	assign offset   = ({3'b000, pos_q} << 3) - {3'b000, pos_q};
	assign end_bit  = offset + 7'd7;
	assign payload  = byte_s1[6:0];

	always_comb begin
		acc_d       = acc_q;
		pos_d       = pos_q;
		kind_d      = eff_kind;
		lost_d      = lost_q;
		res_valid   = 1'b0;
		res_value   = acc_q;
		res_ovf     = 1'b0;
		field_clear = 1'b0;
		priority if (pos_q == '0 && kind_s1 > KIND_SLEB) begin
			// unused kind on a first byte: swallowed, no field starts
			kind_d = kind_q;
		end else if (eff_kind <= KIND_U64) begin
			// fixed-width field, byte order as the register stands now
			if (little_endian_q) begin
				acc_d = acc_q | (ValueW'(byte_s1) << {pos_q[2:0], 3'b000});
			end else begin
				acc_d = {acc_q[ValueW-ByteW-1:0], byte_s1};
			end
			pos_d = pos_inc;
			if (pos_inc == nbytes) begin
				res_valid   = 1'b1;
				res_value   = acc_d;
				field_clear = 1'b1;
			end
		end else begin
			// leb128 field, 7 payload bits per byte
			if (pos_q < LEB_TOP_POS) begin
				acc_d = acc_q | (ValueW'(payload) << offset[5:0]);
			end else if (pos_q == LEB_TOP_POS) begin
				acc_d[ValueW-1] = acc_q[ValueW-1] | payload[0];
				lost_d          = lost_q | (payload[6:1] != '0);
			end else begin
				lost_d = lost_q | (payload != '0);
			end
			if (pos_q < LEB_LAST_POS) begin
				pos_d = pos_inc;
			end
			if (!byte_s1[7]) begin
				res_valid = 1'b1;
				res_value = acc_d;
				// sign fill only while the field ends below bit 64
				if (eff_kind == KIND_SLEB && byte_s1[6] && end_bit < 7'd64) begin
					res_value = acc_d | ({ValueW{1'b1}} << end_bit[5:0]);
				end
				res_ovf     = lost_d;
				field_clear = 1'b1;
			end
		end
	end

	// field state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			kind_q <= KIND_U8;
			lost_q <= 1'b0;
		end else if (step) begin
			if (field_clear) begin
				acc_q  <= '0;
				pos_q  <= '0;
				kind_q <= KIND_U8;
				lost_q <= 1'b0;
			end else begin
				acc_q  <= acc_d;
				pos_q  <= pos_d;
				kind_q <= kind_d;
				lost_q <= lost_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			value_s2 <= res_value;
			ovf_s2   <= res_ovf;
		end
	end

	assign out_valid = valid_s2;
	assign value     = value_s2;
	assign overflow  = ovf_s2;

	// checks
	`ASSERT_ALWAYS(a_pos_range, pos_q <= LEB_LAST_POS, "byte position past leb128 limit")
	`ASSERT_IMPLY(a_fixed_pos, pos_q != '0 && kind_q <= KIND_U64, pos_q < (4'd1 << kind_q[1:0]), "fixed field ran past its size")
	`ASSERT_IMPLY(a_lost_late, lost_q, pos_q == LEB_LAST_POS && kind_q >= KIND_ULEB, "lost bits outside a long leb128 field")
	`ASSERT_IMPLY(a_idle_clean, pos_q == '0, acc_q == '0 && !lost_q, "state not clear between fields")
	`ASSERT_IMPLY(a_stall_cause, in_stall, valid_s1 && valid_s2 && out_stall, "input stalled without a held result")

endmodule

// ===== test/tb_binary_field_byte_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_field_byte_decoder_unit
// self-checking bench for the tagged byte stream field decoder: a queue fed
// driver offers words with random gaps, a model of the field state predicts
// each finished field, and a monitor compares every result word in order
// ----------------------------------------------------------------------------
module tb_binary_field_byte_decoder_unit;
	import bfbd_pkg::*;

	// kind codes that start no field
	localparam kind_t KIND_SPARE_A = 3'd6;
	localparam kind_t KIND_SPARE_B = 3'd7;

	// cycles without any transfer before the run is declared hung
	localparam int unsigned HANG_LIMIT = 2000;
	// receiver hold-off that backs the pipe up into the input side
	localparam int unsigned LONG_HOLD = 80;
	// words per random phase
	localparam int unsigned PHASE_WORDS = 205;
	localparam int unsigned NUM_PHASES = 6;

	typedef struct packed {
		kind_t kind;
		byte_t data;
	} in_word_t;

	typedef struct packed {
		value_t value;
		logic   overflow;
	} field_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_we = 1'b0;
	logic   cfg_wdata = 1'b1;
	logic   in_valid = 1'b0;
	logic   in_stall;
	kind_t  kind = KIND_U8;
	byte_t  data_byte = 8'h00;
	logic   out_valid;
	logic   out_stall = 1'b0;
	value_t value;
	logic   overflow;

	binary_field_byte_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.overflow  (overflow)
	);

	always #2 clk = ~clk;

	// words waiting to be offered, and fields the decoder still owes us
	in_word_t words_to_send[$];
	field_t   fields_due[$];

	int unsigned n_queued = 0;
	int unsigned n_taken = 0;
	int unsigned n_errors = 0;

	// run-wide knobs set by the sequencer
	logic quiet_tail = 1'b0;
	logic hold_ask = 1'b0;

	// ------------------------------------------------------------------
	// field decoder model: its own copy of the field state and byte order
	// ------------------------------------------------------------------
	logic        little_end = 1'b1;
	value_t      acc_bits = '0;
	int unsigned pos_count = 0;
	kind_t       cur_kind = KIND_U8;
	logic        bits_lost = 1'b0;

	task automatic clear_field_state();
		acc_bits = '0;
		pos_count = 0;
		cur_kind = KIND_U8;
		bits_lost = 1'b0;
	endtask

	// folds one accepted word into the model, queues a field when one ends
	task automatic decode_word(input kind_t k, input byte_t octet);
		int unsigned nbytes;
		int unsigned p;
		int unsigned end_bit;
		logic [6:0]  pay;
		field_t      done;
		// the kind only counts on the first byte of a field
		if (pos_count == 0) begin
			if (k > KIND_SLEB)
				return;
			cur_kind = k;
		end
		if (cur_kind <= KIND_U64) begin
			nbytes = 1 << cur_kind;
			// byte order taken per word, so a mid-field switch mixes orders
			if (little_end)
				acc_bits |= value_t'(octet) << ((8 * pos_count) & 63);
			else
				acc_bits = {acc_bits[ValueW-9:0], octet};
			pos_count++;
			if (pos_count >= nbytes) begin
				done.value = acc_bits;
				done.overflow = 1'b0;
				fields_due.push_back(done);
				clear_field_state();
			end
			return;
		end
		// leb128: 7 payload bits per byte, low group first
		pay = octet[6:0];
		p = pos_count;
		if (p < LEB_TOP_POS) begin
			acc_bits |= value_t'(pay) << (7 * p);
		end else if (p == LEB_TOP_POS) begin
			// only bit 0 lands at bit 63, the rest is lost
			acc_bits[ValueW-1] = acc_bits[ValueW-1] | pay[0];
			if (pay[6:1] != 0)
				bits_lost = 1'b1;
		end else if (pay != 0) begin
			bits_lost = 1'b1;
		end
		if (pos_count < LEB_LAST_POS)
			pos_count++;
		if (!octet[7]) begin
			done.value = acc_bits;
			end_bit = 7 * (p + 1);
			// sign fill only when the field stops short of bit 64
			if (cur_kind == KIND_SLEB && octet[6] && end_bit < ValueW)
				done.value |= ~value_t'(0) << end_bit;
			done.overflow = bits_lost;
			fields_due.push_back(done);
			clear_field_state();
		end
	endtask

	// ------------------------------------------------------------------
	// driver: offers queued words, with bursts of idle cycles between them
	// ------------------------------------------------------------------
	int unsigned in_gap = 0;
	int unsigned in_run = 0;
	in_word_t    next_word;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			// the current word went through, or nothing is on offer
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (words_to_send.size() != 0) begin
				next_word = words_to_send.pop_front();
				in_valid <= 1'b1;
				kind <= next_word.kind;
				data_byte <= next_word.data;
				// pick the next idle burst once a busy stretch runs out
				if (!quiet_tail) begin
					if (in_run == 0) begin
						in_gap = $urandom_range(1, 14);
						in_run = $urandom_range(0, 30);
					end else begin
						in_run--;
					end
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stall bursts plus one long hold-off on request
	// ------------------------------------------------------------------
	int unsigned out_gap = 0;
	int unsigned out_run = 0;
	int unsigned hold_left = 0;
	logic        hold_begun = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_ask && !hold_begun) begin
				hold_begun = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				// keep the output blocked so the decoder fills and pushes back
				hold_left--;
				out_stall <= 1'b1;
			end else if (quiet_tail) begin
				out_stall <= 1'b0;
			end else if (out_gap != 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (out_run == 0) begin
					out_gap = $urandom_range(1, 14);
					out_run = $urandom_range(0, 40);
				end else begin
					out_run--;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: model update on each input word, check on each result word
	// ------------------------------------------------------------------
	field_t oldest;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_word(kind, data_byte);
				n_taken++;
			end
			if (out_valid && !out_stall) begin
				if (fields_due.size() == 0) begin
					$error("unexpected result word: value %h overflow %b", value, overflow);
					n_errors++;
				end else begin
					oldest = fields_due.pop_front();
					if (value !== oldest.value) begin
						$error("value mismatch: expected %h, actual %h", oldest.value, value);
						n_errors++;
					end
					if (overflow !== oldest.overflow) begin
						$error("overflow mismatch: expected %b, actual %b",
							oldest.overflow, overflow);
						n_errors++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long with no transfer on either side means a hang
	// ------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic send(input kind_t k, input byte_t octet);
		in_word_t w;
		w.kind = k;
		w.data = octet;
		words_to_send.push_back(w);
		n_queued++;
	endtask

	// wait for every word to go in and every field to come out, then let
	// a word with no result drain from the input register
	task automatic settle();
		while (n_taken != n_queued || fields_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_order(input logic le);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= le;
		@(posedge clk);
		cfg_we <= 1'b0;
		little_end = le;
		@(negedge clk);
	endtask

	// one random field or stray word; later bytes of a field carry junk kinds that must be ignored
	task automatic add_random_field();
		int unsigned sel;
		int unsigned len;
		int unsigned i;
		kind_t       k;
		logic [6:0]  pay;
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			// stray word with an unused kind between fields
			send(kind_t'($urandom_range(KIND_SPARE_A, KIND_SPARE_B)), byte_t'($urandom));
		end else if (sel <= 8) begin
			k = kind_t'($urandom_range(KIND_U8, KIND_U64));
			len = 1 << k;
			for (i = 0; i < len; i++)
				send((i == 0) ? k : kind_t'($urandom_range(0, 7)), byte_t'($urandom));
		end else begin
			k = sel[0] ? KIND_SLEB : KIND_ULEB;
			sel = $urandom_range(0, 9);
			if (sel < 6)
				len = $urandom_range(1, 3);
			else if (sel < 8)
				len = $urandom_range(4, 8);
			else if (sel == 8)
				len = $urandom_range(9, 10);
			else
				len = $urandom_range(11, 13);
			for (i = 0; i < len; i++) begin
				if (i > LEB_TOP_POS)
					pay = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'd0;
				else if (i == LEB_TOP_POS)
					pay = $urandom_range(0, 1) ? 7'($urandom) : 7'($urandom_range(0, 1));
				else
					pay = 7'($urandom);
				send((i == 0) ? k : kind_t'($urandom_range(0, 7)),
					byte_t'({(i != len - 1), pay}));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	int unsigned ph;
	int unsigned j;
	int unsigned phase_start;

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words with the byte order left at its reset value
		send(KIND_SPARE_B, 8'h55);      // unused kinds start nothing
		send(KIND_SPARE_A, 8'hAA);
		send(KIND_U8, 8'h00);
		send(KIND_U8, 8'hFF);
		send(KIND_U16, 8'h34);          // second byte kind is ignored
		send(KIND_SPARE_B, 8'h12);
		send(KIND_ULEB, 8'h7F);
		send(KIND_SLEB, 8'h40);         // sign filled from bit 6
		send(KIND_SLEB, 8'h3F);
		// ten byte signed field: top group partly dropped, overflow set
		for (j = 0; j < 9; j++)
			send((j == 0) ? KIND_SLEB : KIND_U8, 8'h80);
		send(KIND_U16, 8'h7F);
		send(KIND_ULEB, 8'h80);         // zero with continuation bytes
		send(KIND_ULEB, 8'h80);
		send(KIND_U8, 8'h00);
		// half a 32 bit field, then the byte order flips under it
		send(KIND_U32, 8'h78);
		send(KIND_U32, 8'h56);
		settle();
		write_order(1'b0);
		send(KIND_ULEB, 8'h34);
		send(KIND_SPARE_A, 8'h12);
		settle();

		// random phases alternating byte order, last one with no idling
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_order(ph[0]);
			quiet_tail = (ph == NUM_PHASES - 1);
			if (ph == 2)
				hold_ask = 1'b1;
			phase_start = n_queued;
			while (n_queued - phase_start < PHASE_WORDS)
				add_random_field();
			// sometimes leave a fixed field open across the next write
			if (ph != NUM_PHASES - 1 && $urandom_range(0, 1))
				send(kind_t'($urandom_range(KIND_U16, KIND_U64)), byte_t'($urandom));
			settle();
		end

		repeat (8) @(negedge clk);
		if (n_errors == 0 && fields_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
